// ===== hw/rtl/software_timer_slot_table_top_assert.svh =====
// Assertion macros shared by the checker of the timer slot table.
// Depends on nothing; included by the checker file.
`ifndef SOFTWARE_TIMER_SLOT_TABLE_TOP_ASSERT_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define STT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("timer slot table: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define STT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("timer slot table: next-cycle check failed");

`endif

// ===== hw/rtl/stt_pkg.sv =====
// Package of the timer slot table: sizes, codes, the slot record and time helpers.
// Depends on nothing; used by every other file of the block but the assertion macro header.
package stt_pkg;

    // Number of slots held in the chain of cells.
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W    = 4;
    localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 16;

    localparam logic [TIME_W-1:0] HIGH_MASK  = 32'hffff_0000;
    localparam logic [TIME_W-1:0] WRAP_STEP  = 32'h0001_0000;
    localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CHECK  = 2'd3
    } func_e_t;

    // Result kinds.
    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_CHECK   = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } stt_state_t;

    // One timer slot as it travels along the chain.
    typedef struct packed {
        logic              armed;
        logic              periodic;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] deadline;
    } slot_rec_t;

    // Extend a 16-bit counter sample to 32-bit time, counting wraps.
    function automatic logic [TIME_W-1:0] advance_time(input logic [TIME_W-1:0] prev,
                                                       input logic [SAMPLE_W-1:0] sample);
        logic [TIME_W-1:0] t;
        t = (prev & HIGH_MASK) | {{(TIME_W-SAMPLE_W){1'b0}}, sample};
        if (prev > t)
        begin
            t = t + WRAP_STEP;
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/stt_in_if.sv =====
// Request channel of the timer slot table: valid, ready and the operation payload.
// Depends on stt_pkg.
interface stt_in_if
    import stt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [SLOT_W-1:0]   slot;
    logic                mode;
    logic [TIME_W-1:0]   period;
    logic [SAMPLE_W-1:0] counter_sample;

    modport source (output valid, func, slot, mode, period, counter_sample, input ready);
    modport sink (input valid, func, slot, mode, period, counter_sample, output ready);
    modport monitor (input valid, ready, func, slot, mode, period, counter_sample);
endinterface

// ===== hw/rtl/stt_out_if.sv =====
// Result channel of the timer slot table: valid, ready and one result beat.
// Depends on stt_pkg.
interface stt_out_if
    import stt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot_out;
    logic              present;
    logic              last;

    modport source (output valid, kind, slot_out, present, last, input ready);
    modport sink (input valid, kind, slot_out, present, last, output ready);
    modport monitor (input valid, ready, kind, slot_out, present, last);
endinterface

// ===== hw/rtl/stt_cell.sv =====
// One cell of the slot ring: holds a single slot record and takes its
// neighbor's record on every shift. Depends on stt_pkg.
module stt_cell
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  slot_rec_t d,
    output slot_rec_t q
);

    logic              armed_reg;
    logic              periodic_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] deadline_reg;

    // Flags come out of reset cleared so every slot starts free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b0;
            periodic_reg <= 1'b0;
        end
        else if (shift)
        begin
            armed_reg    <= d.armed;
            periodic_reg <= d.periodic;
        end
    end

    // Period and deadline are only read while the slot is armed.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            period_reg   <= d.period;
            deadline_reg <= d.deadline;
        end
    end

    assign q = '{armed: armed_reg, periodic: periodic_reg,
                 period: period_reg, deadline: deadline_reg};

endmodule

// ===== hw/rtl/stt_ctrl.sv =====
// Sequencer of the timer slot table: time extension, head-of-ring update,
// expiry ordering and the result register. Depends on stt_pkg and the channel interfaces.
module stt_ctrl
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    req,
    stt_out_if.source rsp,
    input  slot_rec_t head,
    output logic      shift,
    output slot_rec_t head_next
);

    stt_state_t          state_reg, state_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    func_e_t             func_reg, func_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                mode_reg, mode_next;
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                chk_present_reg, chk_present_next;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_present_reg;
    logic                out_last_reg;

    logic                push;
    logic                push_kind;
    logic [SLOT_W-1:0]   push_slot;
    logic                push_present;
    logic                push_last;

    logic                out_free;
    logic                match;
    logic                expired;
    logic                last_idx;
    logic [TIME_W-1:0]   age;
    logic [TIME_W-1:0]   reload_dl;
    logic [TIME_W-1:0]   add_dl;

    // Per-cycle arithmetic on the record at the head of the ring.
    always_comb
    begin
        out_free  = !out_valid_reg || rsp.ready;
        match     = (CMP_W'(idx_reg) == CMP_W'(slot_reg));
        age       = now_reg - head.deadline;
        expired   = head.armed && (age < HALF_RANGE);
        reload_dl = now_reg + head.period;
        add_dl    = now_reg + period_reg;
        last_idx  = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    end

    // State and item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            now_reg         <= '0;
            func_reg        <= FUNC_TICK;
            idx_reg         <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            now_reg         <= now_next;
            func_reg        <= func_next;
            idx_reg         <= idx_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    // Payload of the current item.
    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        mode_reg        <= mode_next;
        period_reg      <= period_next;
        pend_idx_reg    <= pend_idx_next;
        chk_present_reg <= chk_present_next;
    end

    // Next state, ring update and result pushes.
    always_comb
    begin
        state_next       = state_reg;
        now_next         = now_reg;
        func_next        = func_reg;
        slot_next        = slot_reg;
        mode_next        = mode_reg;
        period_next      = period_reg;
        idx_next         = idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        chk_present_next = chk_present_reg;
        shift            = 1'b0;
        head_next        = head;
        push             = 1'b0;
        push_kind        = KIND_EXPIRED;
        push_slot        = SLOT_W'(pend_idx_reg);
        push_present     = 1'b0;
        push_last        = 1'b0;
        req.ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    now_next         = advance_time(now_reg, req.counter_sample);
                    func_next        = func_e_t'(req.func);
                    slot_next        = req.slot;
                    mode_next        = req.mode;
                    period_next      = req.period;
                    idx_next         = '0;
                    pend_valid_next  = 1'b0;
                    chk_present_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                shift = 1'b1;
                unique case (func_reg)
                    FUNC_TICK:
                    begin
                        if (expired)
                        begin
                            if (head.periodic)
                            begin
                                head_next.deadline = reload_dl;
                            end
                            else
                            begin
                                head_next.armed = 1'b0;
                            end
                            // An earlier expiry waits until this one shows it is not last.
                            if (pend_valid_reg)
                            begin
                                if (out_free)
                                begin
                                    push = 1'b1;
                                end
                                else
                                begin
                                    shift = 1'b0;
                                end
                            end
                            if (shift)
                            begin
                                pend_valid_next = 1'b1;
                                pend_idx_next   = idx_reg;
                            end
                        end
                    end
                    FUNC_ADD:
                    begin
                        if (match)
                        begin
                            head_next = '{armed: 1'b1, periodic: mode_reg,
                                          period: period_reg, deadline: add_dl};
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (match)
                        begin
                            head_next.armed = 1'b0;
                        end
                    end
                    FUNC_CHECK:
                    begin
                        if (match)
                        begin
                            chk_present_next = head.armed;
                        end
                    end
                endcase

                if (shift)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (func_reg == FUNC_TICK && pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (func_reg == FUNC_CHECK)
                begin
                    if (out_free)
                    begin
                        push         = 1'b1;
                        push_kind    = KIND_CHECK;
                        push_slot    = slot_reg;
                        push_present = chk_present_reg;
                        push_last    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: holds a beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg    <= push_kind;
            out_slot_reg    <= push_slot;
            out_present_reg <= push_present;
            out_last_reg    <= push_last;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.slot_out = out_slot_reg;
    assign rsp.present  = out_present_reg;
    assign rsp.last     = out_last_reg;

endmodule

// ===== hw/rtl/software_timer_slot_table_top.sv =====
// Every request beat carries a 16-bit counter sample that is extended to a 32-bit time
// (upper half kept, 0x10000 added on wrap); the operation is tick, add, remove or check.
// The slots live in a ring of NUM_SLOTS cells that rotates one place per cycle past a
// single update point. Each beat is accepted, the ring is rotated once through, and a
// final step sends the last result of a check or of a tick with expiries; add, remove
// and a tick with none send no result. A tick sends its expired slots in index order,
// the last one flagged, and the rotation pauses while the result register waits on
// the sink. A new request is taken while the previous final result still waits there.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_cell and stt_ctrl.
module software_timer_slot_table_top
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    req,
    stt_out_if.source rsp
);

    slot_rec_t cell_q [NUM_SLOTS];
    slot_rec_t cell_d [NUM_SLOTS];
    slot_rec_t head_next;
    logic      shift;

    // Sequencer working on the record at cell zero.
    stt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .head      (cell_q[0]),
        .shift     (shift),
        .head_next (head_next)
    );

    // Ring of cells: each one takes from its upper neighbor, the top one from the head update.
    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_cell
        if (k == NUM_SLOTS - 1)
        begin : g_tail
            assign cell_d[k] = head_next;
        end
        else
        begin : g_link
            assign cell_d[k] = cell_q[k+1];
        end

        stt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d[k]),
            .q     (cell_q[k])
        );
    end

endmodule

// ===== hw/rtl/stt_checker.sv =====
// Port-level checks of the timer slot table, bound to the top level.
// Depends on stt_pkg, the channel interfaces and the assertion macro header.
`include "software_timer_slot_table_top_assert.svh"

module stt_checker
    import stt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_kind,
    input logic [SLOT_W-1:0] rsp_slot_out,
    input logic              rsp_present,
    input logic              rsp_last
);

    logic [SLOT_W+2:0] rsp_payload;

    // The whole result payload, so that it can be watched as one value.
    assign rsp_payload = {rsp_kind, rsp_slot_out, rsp_present, rsp_last};

    // A result beat that is not taken stays and keeps its payload.
    `STT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // One request at a time: ready drops right after a request beat.
    `STT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    // A check answer is always the only, hence last, result of its request.
    `STT_ASSERT_IMP(a_check_is_last, clk, rst_n, rsp_valid && rsp_kind == KIND_CHECK, rsp_last)

    // An expiry notice never claims presence.
    `STT_ASSERT_IMP(a_expired_no_present, clk, rst_n, rsp_valid && rsp_kind == KIND_EXPIRED, !rsp_present)

endmodule

bind software_timer_slot_table_top stt_checker u_stt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_slot_out (rsp.slot_out),
    .rsp_present  (rsp.present),
    .rsp_last     (rsp.last)
);
